@@ hw/rtl/mbrot_pkg.sv @@
// ----------------------------------------------------------------------------
// mbrot_pkg
// Shared types, widths, register indexes and reset values of the
// escape-time pixel core.
// ----------------------------------------------------------------------------
package mbrot_pkg;

	localparam int PIX_W      = 16;
	localparam int COORD_W    = 32;
	localparam int HGT_W      = 16;
	localparam int LIMIT_W    = 16;
	localparam int RED_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int FRAC_BITS_DEF  = 28;
	localparam int COUNT_BITS_DEF = 16;

	// |z| < 2 tested on the squared magnitude
	localparam int ESC_RADIUS = 2;

	localparam logic [CFG_IDX_W-1:0] REG_X_MIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_MAX      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MIN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MAX      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 3'd5;

	localparam logic signed [COORD_W-1:0] X_MIN_RST  = -32'sd536870912;
	localparam logic signed [COORD_W-1:0] X_MAX_RST  = 32'sd536870912;
	localparam logic signed [COORD_W-1:0] Y_MIN_RST  = -32'sd536870912;
	localparam logic signed [COORD_W-1:0] Y_MAX_RST  = 32'sd536870912;
	localparam logic [HGT_W-1:0]          HEIGHT_RST = 16'd480;
	localparam logic [LIMIT_W-1:0]        LIMIT_RST  = 16'd250;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAP_DIFF,
		ST_MAP_MUL,
		ST_MAP_ABS,
		ST_MAP_DIV,
		ST_MAP_FIN,
		ST_ITER_RR,
		ST_ITER_II,
		ST_ITER_RI,
		ST_ITER_UPD,
		ST_DONE
	} state_t;

endpackage

@@ hw/rtl/mbrot_pixel_if.sv @@
// ----------------------------------------------------------------------------
// mbrot_pixel_if
// Pixel coordinate channel: valid/ready handshake with the pixel position.
// ----------------------------------------------------------------------------
interface mbrot_pixel_if
	import mbrot_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_x;
	logic [PIX_W-1:0] pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

@@ hw/rtl/mbrot_result_if.sv @@
// ----------------------------------------------------------------------------
// mbrot_result_if
// Result channel: valid/ready handshake with the escape count of one pixel.
// ----------------------------------------------------------------------------
interface mbrot_result_if
	import mbrot_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [PIX_W-1:0]   out_x;
	logic [PIX_W-1:0]   out_y;
	logic [LIMIT_W-1:0] escape_count;
	logic [RED_W-1:0]   red_level;

	modport source (
		output valid, output out_x, output out_y, output escape_count,
		output red_level, input ready
	);
	modport sink (
		input valid, input out_x, input out_y, input escape_count,
		input red_level, output ready
	);
endinterface

@@ hw/rtl/mandelbrot_escape_time_pixel_core.sv @@
// Each axis mapping runs MAP_DIFF, MAP_MUL, MAP_ABS, the 48-step restoring divider in MAP_DIV, then MAP_FIN.
// Each iteration steps through ITER_RR, ITER_II, ITER_RI and ITER_UPD on the one shared 33x33 multiplier.
// A new pixel is accepted only in idle, after the last result is loaded; a result waiting in the output reg holds it.
// Reset: config registers load their defaults, the sequencer idles, no result valid.
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_core
// Maps a pixel to a point c in signed fixed point and counts z = z*z + c
// iterations until |z| >= 2 or the iteration limit is reached.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_core
	import mbrot_pkg::*;
#(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	mbrot_pixel_if.sink           pixel,
	mbrot_result_if.source        result,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int MUL_OP_W = COORD_W + 1;
	localparam int PROD_W   = 2 * MUL_OP_W;
	localparam int NUM_W    = PIX_W + COORD_W;
	localparam int MAP_W    = NUM_W + 2;
	localparam int DCNT_W   = $clog2(NUM_W);
	localparam int SQ_W     = 2 * COORD_W - FRAC_BITS;
	localparam int RI_W     = SQ_W + 1;
	localparam int DSQ_W    = SQ_W + 1;
	localparam int RE_W     = ((DSQ_W > COORD_W) ? DSQ_W : COORD_W) + 1;
	localparam int IM_W     = ((RI_W > COORD_W) ? RI_W : COORD_W) + 1;
	localparam int CMP_W    = (SQ_W + 1 > FRAC_BITS + 3) ? SQ_W + 1 : FRAC_BITS + 3;

	localparam logic [CMP_W-1:0]      FOUR    = CMP_W'(ESC_RADIUS * ESC_RADIUS) << FRAC_BITS;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [DCNT_W-1:0]     DIV_LAST = DCNT_W'(NUM_W - 1);

	// configuration
	logic signed [COORD_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
	logic [HGT_W-1:0]          height_q;
	logic [LIMIT_W-1:0]        iter_limit_q;

	// sequencer
	state_t state_q, state_d;
	logic   axis_q;

	// item
	logic [PIX_W-1:0]      px_q, py_q;
	logic [COUNT_BITS-1:0] limit_q;
	logic [COUNT_BITS-1:0] cnt_q;

	// mapping
	logic signed [MUL_OP_W-1:0] diff_q;
	logic                       neg_q;
	logic [NUM_W-1:0]           num_q;
	logic [HGT_W-1:0]           rem_q;
	logic [DCNT_W-1:0]          dcnt_q;
	logic signed [COORD_W-1:0]  c_re_q, c_im_q;

	// iteration
	logic signed [COORD_W-1:0] z_re_q, z_im_q;
	logic signed [SQ_W-1:0]    rr_q;
	logic signed [DSQ_W-1:0]   dsq_q;
	logic                      esc_q;

	// shared multiplier
	logic signed [MUL_OP_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0]   prod_q;
	logic                       mul_en;

	// output register
	logic               res_valid_q;
	logic [PIX_W-1:0]   res_x_q, res_y_q;
	logic [LIMIT_W-1:0] res_count_q;
	logic [RED_W-1:0]   res_red_q;
	logic               res_load;

	// combinational datapath
	logic signed [COORD_W-1:0] lo_sel, hi_sel;
	logic [PIX_W-1:0]          pix_sel;
	logic [HGT_W-1:0]          divisor;
	logic [HGT_W:0]            partial;
	logic                      qbit;
	logic signed [PROD_W-1:0]  prod_mag;
	logic signed [MAP_W-1:0]   map_sum;
	logic                      map_ovf;
	logic signed [COORD_W-1:0] map_sat;
	logic signed [SQ_W-1:0]    ii_w;
	logic signed [RI_W-1:0]    ri_w;
	logic [CMP_W-1:0]          mag_sq;
	logic signed [RE_W-1:0]    re_sum;
	logic signed [IM_W-1:0]    im_sum;
	logic                      re_ovf, im_ovf;
	logic signed [COORD_W-1:0] z_re_next, z_im_next;
	logic [COUNT_BITS-1:0]     cnt_inc;
	logic [COUNT_BITS-1:0]     limit_new;

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (pixel.valid) state_d = ST_MAP_DIFF;
			ST_MAP_DIFF: state_d = ST_MAP_MUL;
			ST_MAP_MUL:  state_d = ST_MAP_ABS;
			ST_MAP_ABS:  state_d = ST_MAP_DIV;
			ST_MAP_DIV:  if (dcnt_q == DIV_LAST) state_d = ST_MAP_FIN;
			ST_MAP_FIN: begin
				if (!axis_q) state_d = ST_MAP_DIFF;
				else if (limit_q == '0) state_d = ST_DONE;
				else state_d = ST_ITER_RR;
			end
			ST_ITER_RR:  state_d = ST_ITER_II;
			ST_ITER_II:  state_d = ST_ITER_RI;
			ST_ITER_RI:  state_d = ST_ITER_UPD;
			ST_ITER_UPD: begin
				if (esc_q || cnt_inc == limit_q) state_d = ST_DONE;
				else state_d = ST_ITER_RR;
			end
			ST_DONE:     if (!res_valid_q || result.ready) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// ---------------- control outputs ----------------
	always_comb begin
		pixel.ready = 1'b0;
		mul_en      = 1'b0;
		res_load    = 1'b0;
		mul_a       = MUL_OP_W'(z_re_q);
		mul_b       = MUL_OP_W'(z_re_q);
		case (state_q)
			ST_IDLE:    pixel.ready = 1'b1;
			ST_MAP_MUL: begin
				mul_en = 1'b1;
				mul_a  = $signed({{(MUL_OP_W - PIX_W){1'b0}}, pix_sel});
				mul_b  = diff_q;
			end
			ST_ITER_RR: mul_en = 1'b1;
			ST_ITER_II: begin
				mul_en = 1'b1;
				mul_a  = MUL_OP_W'(z_im_q);
				mul_b  = MUL_OP_W'(z_im_q);
			end
			ST_ITER_RI: begin
				mul_en = 1'b1;
				mul_b  = MUL_OP_W'(z_im_q);
			end
			ST_DONE:    res_load = !res_valid_q || result.ready;
			default:    ;
		endcase
	end

	// ---------------- datapath logic ----------------
	always_comb begin
		lo_sel  = axis_q ? y_min_q : x_min_q;
		hi_sel  = axis_q ? y_max_q : x_max_q;
		pix_sel = axis_q ? py_q : px_q;
		divisor = (height_q == '0) ? HGT_W'(1) : height_q;

		partial = {rem_q, num_q[NUM_W-1]};
		qbit    = partial >= {1'b0, divisor};

		prod_mag = prod_q[PROD_W-1] ? -prod_q : prod_q;

		map_sum = neg_q ? MAP_W'(lo_sel) - $signed({2'b00, num_q})
		                : MAP_W'(lo_sel) + $signed({2'b00, num_q});
		map_ovf = !((&map_sum[MAP_W-1:COORD_W-1]) || !(|map_sum[MAP_W-1:COORD_W-1]));
		map_sat = map_ovf ? {map_sum[MAP_W-1], {(COORD_W-1){~map_sum[MAP_W-1]}}}
		                  : map_sum[COORD_W-1:0];

		ii_w   = SQ_W'(prod_q >>> FRAC_BITS);
		ri_w   = RI_W'(prod_q >>> (FRAC_BITS - 1));
		mag_sq = {{(CMP_W - SQ_W){1'b0}}, rr_q} + {{(CMP_W - SQ_W){1'b0}}, ii_w};

		re_sum = RE_W'(dsq_q) + RE_W'(c_re_q);
		im_sum = IM_W'(ri_w) + IM_W'(c_im_q);
		re_ovf = !((&re_sum[RE_W-1:COORD_W-1]) || !(|re_sum[RE_W-1:COORD_W-1]));
		im_ovf = !((&im_sum[IM_W-1:COORD_W-1]) || !(|im_sum[IM_W-1:COORD_W-1]));
		z_re_next = re_ovf ? {re_sum[RE_W-1], {(COORD_W-1){~re_sum[RE_W-1]}}}
		                   : re_sum[COORD_W-1:0];
		z_im_next = im_ovf ? {im_sum[IM_W-1], {(COORD_W-1){~im_sum[IM_W-1]}}}
		                   : im_sum[COORD_W-1:0];

		cnt_inc   = cnt_q + COUNT_BITS'(1);
		limit_new = (iter_limit_q > LIMIT_W'(CNT_MAX)) ? CNT_MAX
		                                               : iter_limit_q[COUNT_BITS-1:0];
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			res_valid_q  <= 1'b0;
			x_min_q      <= X_MIN_RST;
			x_max_q      <= X_MAX_RST;
			y_min_q      <= Y_MIN_RST;
			y_max_q      <= Y_MAX_RST;
			height_q     <= HEIGHT_RST;
			iter_limit_q <= LIMIT_RST;
		end else begin
			state_q <= state_d;
			if (res_load) res_valid_q <= 1'b1;
			else if (result.ready) res_valid_q <= 1'b0;
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_X_MIN:      x_min_q      <= cfg_data;
					REG_X_MAX:      x_max_q      <= cfg_data;
					REG_Y_MIN:      y_min_q      <= cfg_data;
					REG_Y_MAX:      y_max_q      <= cfg_data;
					REG_HEIGHT:     height_q     <= cfg_data[HGT_W-1:0];
					REG_ITER_LIMIT: iter_limit_q <= cfg_data[LIMIT_W-1:0];
					default:        ;
				endcase
			end
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (mul_en) prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: begin
				if (pixel.valid) begin
					px_q    <= pixel.pixel_x;
					py_q    <= pixel.pixel_y;
					limit_q <= limit_new;
					axis_q  <= 1'b0;
				end
			end
			ST_MAP_DIFF: diff_q <= MUL_OP_W'(hi_sel) - MUL_OP_W'(lo_sel);
			ST_MAP_ABS: begin
				neg_q  <= prod_q[PROD_W-1];
				num_q  <= prod_mag[NUM_W-1:0];
				rem_q  <= '0;
				dcnt_q <= '0;
			end
			ST_MAP_DIV: begin
				rem_q  <= qbit ? HGT_W'(partial - {1'b0, divisor}) : partial[HGT_W-1:0];
				num_q  <= {num_q[NUM_W-2:0], qbit};
				dcnt_q <= dcnt_q + DCNT_W'(1);
			end
			ST_MAP_FIN: begin
				if (axis_q) begin
					c_im_q <= map_sat;
				end else begin
					c_re_q <= map_sat;
				end
				axis_q <= 1'b1;
				z_re_q <= '0;
				z_im_q <= '0;
				cnt_q  <= '0;
			end
			ST_ITER_II: rr_q <= SQ_W'(prod_q >>> FRAC_BITS);
			ST_ITER_RI: begin
				dsq_q <= DSQ_W'(rr_q) - DSQ_W'(ii_w);
				esc_q <= mag_sq >= FOUR;
			end
			ST_ITER_UPD: begin
				if (!esc_q) begin
					z_re_q <= z_re_next;
					z_im_q <= z_im_next;
					cnt_q  <= cnt_inc;
				end
			end
			default: ;
		endcase
		if (res_load) begin
			res_x_q     <= px_q;
			res_y_q     <= py_q;
			res_count_q <= LIMIT_W'(cnt_q);
			res_red_q   <= cnt_q[RED_W-1:0];
		end
	end

	assign result.valid        = res_valid_q;
	assign result.out_x        = res_x_q;
	assign result.out_y        = res_y_q;
	assign result.escape_count = res_count_q;
	assign result.red_level    = res_red_q;

endmodule
